>>> rtl/quaternion_to_euler_angles_defines.svh
// Assertion macros shared by the quaternion to Euler angle RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qte assertion failed");

// Next-cycle implication, checked outside reset.
`define QTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qte assertion failed");

`endif

>>> rtl/qte_pkg.sv
// Shared constants and the arctangent table for the quaternion to Euler pipeline.
// No dependencies; used by the cell modules and the top level.
package qte_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ACC_FRAC     = 24;
    localparam int ZW           = 34;
    localparam int ASIN_FRAC    = 30;
    localparam int T_W          = ASIN_FRAC + 1;
    localparam int SQ_BITS      = ASIN_FRAC;
    localparam int SQ_RW        = 2 * ASIN_FRAC - 1;

    localparam logic signed [ZW-1:0] Z_DEG90 = 34'sd1509949440;

    // atan(2^-i) in degrees with 24 fraction bits, rounded.
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sd754974720;
            1:  v = 34'sd445687602;
            2:  v = 34'sd235489088;
            3:  v = 34'sd119537938;
            4:  v = 34'sd60000934;
            5:  v = 34'sd30029717;
            6:  v = 34'sd15018523;
            7:  v = 34'sd7509720;
            8:  v = 34'sd3754917;
            9:  v = 34'sd1877466;
            10: v = 34'sd938734;
            11: v = 34'sd469367;
            12: v = 34'sd234684;
            13: v = 34'sd117342;
            14: v = 34'sd58671;
            15: v = 34'sd29335;
            16: v = 34'sd14668;
            17: v = 34'sd7334;
            18: v = 34'sd3667;
            19: v = 34'sd1833;
            20: v = 34'sd917;
            21: v = 34'sd458;
            22: v = 34'sd229;
            23: v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/qte_sqrt_cell.sv
// One bit of the pipelined integer square root, plus a side payload shift stage.
// Depends on qte_pkg for the remainder and root widths.
module qte_sqrt_cell #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [qte_pkg::SQ_RW-1:0]   i_rem,
    input  logic [qte_pkg::SQ_BITS-1:0] i_root,
    input  logic [SIDE_W-1:0]           i_side,
    output logic [qte_pkg::SQ_RW-1:0]   o_rem,
    output logic [qte_pkg::SQ_BITS-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int TW = qte_pkg::SQ_RW + 3;

    logic [TW-1:0]                 w_trial;
    logic [TW-1:0]                 w_rem_ext;
    logic                          w_take;
    logic [qte_pkg::SQ_RW-1:0]     n_rem;
    logic [qte_pkg::SQ_BITS-1:0]   n_root;
    logic [qte_pkg::SQ_RW-1:0]     r_rem;
    logic [qte_pkg::SQ_BITS-1:0]   r_root;
    logic [SIDE_W-1:0]             r_side;

    // Setting this bit costs (2*root + 2^BIT) * 2^BIT of the remainder.
    assign w_trial   = (TW'(i_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign w_rem_ext = TW'(i_rem);
    assign w_take    = (w_rem_ext >= w_trial);

    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        if (w_take) begin
            n_rem  = qte_pkg::SQ_RW'(w_rem_ext - w_trial);
            n_root = i_root | (qte_pkg::SQ_BITS'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

>>> rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation for a single lane, registered.
// Depends on qte_pkg for the angle width and the arctangent table.
module qte_cordic_cell #(
    parameter int CW   = 36,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [CW-1:0]          i_x,
    input  logic signed [CW-1:0]          i_y,
    input  logic signed [qte_pkg::ZW-1:0] i_z,
    input  logic                          i_zero,
    output logic signed [CW-1:0]          o_x,
    output logic signed [CW-1:0]          o_y,
    output logic signed [qte_pkg::ZW-1:0] o_z,
    output logic                          o_zero
);
    logic signed [CW-1:0]          w_dx;
    logic signed [CW-1:0]          w_dy;
    logic signed [CW-1:0]          n_x;
    logic signed [CW-1:0]          n_y;
    logic signed [qte_pkg::ZW-1:0] n_z;
    logic signed [CW-1:0]          r_x;
    logic signed [CW-1:0]          r_y;
    logic signed [qte_pkg::ZW-1:0] r_z;
    logic                          r_zero;

    assign w_dx = i_x >>> STEP;
    assign w_dy = i_y >>> STEP;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + w_dy;
            n_y = i_y - w_dx;
            n_z = i_z + qte_pkg::atan_deg(STEP);
        end else begin
            n_x = i_x - w_dy;
            n_y = i_y + w_dx;
            n_z = i_z - qte_pkg::atan_deg(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_zero = r_zero;
endmodule

>>> rtl/quaternion_to_euler_angles.sv
// Top level: quaternion in, ZYX Euler angles (roll, pitch, yaw + 180) out.
// Depends on qte_pkg, qte_sqrt_cell, qte_cordic_cell and the defines header.
//
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_quat_w, i_quat_x, i_quat_y, i_quat_z
// result    out        o_valid / i_stall    o_roll_deg, o_pitch_deg, o_yaw_deg,
//                                           o_pitch_clipped
//
// Each request passes through 4 product and setup stages, 30 square root
// cells, one pre-rotation stage, 24 CORDIC steps of three lane cells each
// and the output register. A new request is taken every cycle unless o_stall is high.
// The whole pipeline moves as one; it halts only while a finished result sits
// in the output register and the consumer stalls it.
// Reset (synchronous, active low) clears only the stage valid bits.
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles #(
    parameter int QUAT_FRAC_BITS  = 14,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_roll_deg,
    output logic signed [13:0] o_pitch_deg,
    output logic [14:0]        o_yaw_deg,
    output logic               o_pitch_clipped
);
    // Vector width: holds 0.5 at the product scale and any sum of two products.
    localparam int VW     = (2 * QUAT_FRAC_BITS + 2 > 34) ? 2 * QUAT_FRAC_BITS + 2 : 34;
    // CORDIC lanes grow by the pre-rotation and the gain of about 1.65.
    localparam int CW     = VW + 2;
    localparam int ZW     = qte_pkg::ZW;
    localparam int T_W    = qte_pkg::T_W;
    localparam int NSQ    = qte_pkg::SQ_BITS;
    localparam int NCS    = qte_pkg::CORDIC_STEPS;
    localparam int SIDE_W = 4 * VW + T_W + 1;
    localparam int NST    = 4 + NSQ + 1 + NCS + 1;
    localparam int ASH_R  = (2 * QUAT_FRAC_BITS >= qte_pkg::ASIN_FRAC) ?
                            2 * QUAT_FRAC_BITS - qte_pkg::ASIN_FRAC : 0;
    localparam int ASH_L  = (2 * QUAT_FRAC_BITS < qte_pkg::ASIN_FRAC) ?
                            qte_pkg::ASIN_FRAC - 2 * QUAT_FRAC_BITS : 0;
    localparam int SH     = qte_pkg::ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [VW-1:0] HALF = {{(VW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);
    localparam logic [qte_pkg::SQ_RW-1:0] SQ_ONE =
        {1'b1, {(qte_pkg::SQ_RW-1){1'b0}}};
    localparam logic signed [ZW-1:0] RND    = {{(ZW-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [ZW-1:0] DEG90  = {{(ZW-1){1'b0}}, 1'b1} * 90 << ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] DEG180 = DEG90 <<< 1;
    localparam logic signed [ZW-1:0] DEG360 = DEG90 <<< 2;

    // Pipeline control: every stage advances unless the output is held.
    logic             w_en;
    logic [NST-1:0]   r_vld;

    assign w_en    = !(r_vld[NST-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Stage 1: the nine quaternion products, exact at 2*QUAT_FRAC_BITS.
    logic signed [31:0] r1_wx, r1_yz, r1_xx, r1_yy, r1_xy, r1_wz, r1_zz, r1_wy, r1_xz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_wx <= i_quat_w * i_quat_x;
            r1_yz <= i_quat_y * i_quat_z;
            r1_xx <= i_quat_x * i_quat_x;
            r1_yy <= i_quat_y * i_quat_y;
            r1_xy <= i_quat_x * i_quat_y;
            r1_wz <= i_quat_w * i_quat_z;
            r1_zz <= i_quat_z * i_quat_z;
            r1_wy <= i_quat_w * i_quat_y;
            r1_xz <= i_quat_x * i_quat_z;
        end
    end

    // Stage 2: atan2 operand pairs for roll and yaw, and the saturated asin
    // argument rescaled to 30 fraction bits (half of the sine itself).
    logic signed [VW-1:0]  w_t;
    logic signed [VW-1:0]  w_tc;
    logic                  w_clip;
    logic signed [VW-1:0]  w_tr;
    logic signed [T_W-1:0] w_ts;
    logic signed [VW-1:0]  r2_rx, r2_ry, r2_yx, r2_yy;
    logic signed [T_W-1:0] r2_t;
    logic                  r2_clip;

    assign w_t = VW'(r1_wy) - VW'(r1_xz);

    always_comb begin
        w_tc   = w_t;
        w_clip = 1'b0;
        if (w_t > HALF) begin
            w_tc   = HALF;
            w_clip = 1'b1;
        end else if (w_t < -HALF) begin
            w_tc   = -HALF;
            w_clip = 1'b1;
        end
    end

    assign w_tr = w_tc >>> ASH_R;
    assign w_ts = w_tr[T_W-1:0] <<< ASH_L;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rx   <= HALF - VW'(r1_xx) - VW'(r1_yy);
            r2_ry   <= VW'(r1_wx) + VW'(r1_yz);
            r2_yx   <= HALF - VW'(r1_yy) - VW'(r1_zz);
            r2_yy   <= VW'(r1_xy) + VW'(r1_wz);
            r2_t    <= w_ts;
            r2_clip <= w_clip;
        end
    end

    // Stage 3: square of the asin argument. Stage 4: radicand 0.25 - t^2.
    logic [NSQ-1:0]          w_tabs;
    logic [2*NSQ-1:0]        r3_sq;
    logic [SIDE_W-1:0]       r3_side;
    logic [qte_pkg::SQ_RW-1:0] r4_v;
    logic [SIDE_W-1:0]       r4_side;

    assign w_tabs = r2_t[T_W-1] ? NSQ'(-r2_t) : NSQ'(r2_t);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sq   <= w_tabs * w_tabs;
            r3_side <= {r2_rx, r2_ry, r2_yx, r2_yy, r2_t, r2_clip};
            r4_v    <= SQ_ONE - r3_sq[qte_pkg::SQ_RW-1:0];
            r4_side <= r3_side;
        end
    end

    // Square root chain: one result bit per cell, most significant first.
    logic [qte_pkg::SQ_RW-1:0] w_rem  [0:NSQ];
    logic [NSQ-1:0]            w_root [0:NSQ];
    logic [SIDE_W-1:0]         w_side [0:NSQ];

    assign w_rem[0]  = r4_v;
    assign w_root[0] = '0;
    assign w_side[0] = r4_side;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        qte_sqrt_cell #(
            .BIT    (NSQ - 1 - g),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .i_side (w_side[g]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // Pre-rotation: lane 0 roll, lane 1 pitch, lane 2 yaw. A vector in the
    // left half plane is turned by a quarter turn; the zero vector is flagged
    // so that its angle reads as zero at the end.
    logic signed [VW-1:0]  w_sx, w_sy, w_sx2, w_sy2;
    logic signed [T_W-1:0] w_st;
    logic                  w_sclip;
    logic signed [VW-1:0]  w_lx [0:2];
    logic signed [VW-1:0]  w_ly [0:2];

    assign {w_sx, w_sy, w_sx2, w_sy2, w_st, w_sclip} = w_side[NSQ];
    assign w_lx[0] = w_sx;
    assign w_ly[0] = w_sy;
    assign w_lx[1] = VW'(w_root[NSQ]);
    assign w_ly[1] = VW'(w_st);
    assign w_lx[2] = w_sx2;
    assign w_ly[2] = w_sy2;

    logic signed [CW-1:0] w_cx   [0:NCS][0:2];
    logic signed [CW-1:0] w_cy   [0:NCS][0:2];
    logic signed [ZW-1:0] w_cz   [0:NCS][0:2];
    logic                 w_czer [0:NCS][0:2];
    logic [NCS:0]         r_clip;

    for (genvar l = 0; l < 3; l++) begin : g_pre
        logic signed [CW-1:0] w_ex, w_ey;
        logic signed [CW-1:0] n_px, n_py;
        logic signed [ZW-1:0] n_pz;
        logic signed [CW-1:0] r_px, r_py;
        logic signed [ZW-1:0] r_pz;
        logic                 r_pzer;

        assign w_ex = CW'(w_lx[l]);
        assign w_ey = CW'(w_ly[l]);

        always_comb begin
            n_px = w_ex;
            n_py = w_ey;
            n_pz = '0;
            if (w_ex[CW-1]) begin
                if (!w_ey[CW-1]) begin
                    n_px = w_ey;
                    n_py = -w_ex;
                    n_pz = qte_pkg::Z_DEG90;
                end else begin
                    n_px = -w_ey;
                    n_py = w_ex;
                    n_pz = -qte_pkg::Z_DEG90;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_px   <= n_px;
                r_py   <= n_py;
                r_pz   <= n_pz;
                r_pzer <= (w_ex == '0) && (w_ey == '0);
            end
        end

        assign w_cx[0][l]   = r_px;
        assign w_cy[0][l]   = r_py;
        assign w_cz[0][l]   = r_pz;
        assign w_czer[0][l] = r_pzer;
    end

    // The saturation flag rides alongside the CORDIC chain.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_clip <= {r_clip[NCS-1:0], w_sclip};
        end
    end

    // CORDIC chain: three lanes, one micro-rotation per cell.
    for (genvar s = 0; s < NCS; s++) begin : g_step
        for (genvar l = 0; l < 3; l++) begin : g_lane
            qte_cordic_cell #(
                .CW   (CW),
                .STEP (s)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_cx[s][l]),
                .i_y    (w_cy[s][l]),
                .i_z    (w_cz[s][l]),
                .i_zero (w_czer[s][l]),
                .o_x    (w_cx[s+1][l]),
                .o_y    (w_cy[s+1][l]),
                .o_z    (w_cz[s+1][l]),
                .o_zero (w_czer[s+1][l])
            );
        end
    end

    // Output stage: round to the output grid with ties upward, then clamp.
    // The x and y outputs of the last cells are not needed.
    logic signed [ZW-1:0] w_ga [0:2];
    logic signed [ZW-1:0] n_roll, n_pitch, n_yaw, w_ysum;
    logic signed [14:0]   r_roll;
    logic signed [13:0]   r_pitch;
    logic [14:0]          r_yaw;
    logic                 r_pclip;

    for (genvar l = 0; l < 3; l++) begin : g_round
        logic signed [ZW-1:0] w_za;
        assign w_za    = w_czer[NCS][l] ? '0 : w_cz[NCS][l];
        assign w_ga[l] = (w_za + RND) >>> SH;
    end

    assign w_ysum = w_ga[2] + DEG180;

    always_comb begin
        n_roll = w_ga[0];
        if (w_ga[0] > DEG180) begin
            n_roll = DEG180;
        end else if (w_ga[0] < -DEG180) begin
            n_roll = -DEG180;
        end
        n_pitch = w_ga[1];
        if (w_ga[1] > DEG90) begin
            n_pitch = DEG90;
        end else if (w_ga[1] < -DEG90) begin
            n_pitch = -DEG90;
        end
        n_yaw = w_ysum;
        if (w_ysum > DEG360) begin
            n_yaw = DEG360;
        end else if (w_ysum < 0) begin
            n_yaw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll  <= n_roll[14:0];
            r_pitch <= n_pitch[13:0];
            r_yaw   <= n_yaw[14:0];
            r_pclip <= r_clip[NCS];
        end
    end

    assign o_roll_deg      = r_roll;
    assign o_pitch_deg     = r_pitch;
    assign o_yaw_deg       = r_yaw;
    assign o_pitch_clipped = r_pclip;

    // A stall toward the producer only ever comes from a held result.
    `QTE_ASSERT_IMP(a_stall_source, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // An accepted request always enters the first stage.
    `QTE_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    // A result that is stalled is still there in the next cycle.
    `QTE_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule
